// ===== rtl/rie_pkg.sv =====
package rie_pkg;

  localparam int unsigned DATA_WORDS_DEF = 256;
  localparam int unsigned NUM_REGS       = 16;
  localparam int unsigned REG_AW         = $clog2(NUM_REGS);
  // byte addresses wrap at 8 bits before the fold onto the memory depth
  localparam int unsigned ADDR_SPACE     = 256;

  typedef logic [7:0]        byte_t;
  typedef logic [REG_AW-1:0] reg_addr_t;

  typedef enum logic [2:0] {
    FN_EXEC   = 3'd0,
    FN_WR_MEM = 3'd1,
    FN_RD_MEM = 3'd2,
    FN_WR_REG = 3'd3,
    FN_RD_REG = 3'd4
  } func_e;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_INC   = 4'd3,
    OP_AND   = 4'd4,
    OP_OR    = 4'd5,
    OP_NOT   = 4'd6,
    OP_XOR   = 4'd7,
    OP_LOAD  = 4'd8,
    OP_STORE = 4'd9,
    OP_JUMP  = 4'd10,
    OP_BRZ   = 4'd11,
    OP_HALT  = 4'd15
  } op_e;

  // decoded word held in the issue stage
  typedef struct packed {
    func_e       func;
    logic [15:0] instr;
    byte_t       pc;
    byte_t       access_addr;
    byte_t       write_value;
    reg_addr_t   rc;          // dest for instructions, access_reg otherwise
  } s1_t;

  // register file write port
  typedef struct packed {
    logic      en;
    reg_addr_t addr;
    byte_t     data;
  } wb_t;

  // data memory request
  typedef struct packed {
    logic  en;
    logic  we;
    byte_t addr;
    byte_t wdata;
  } dmem_req_t;

  // execute stage result
  typedef struct packed {
    logic      wr;
    logic      ld;
    logic      rd_mem;
    reg_addr_t dst;
    byte_t     val;
    byte_t     rv;
    byte_t     next_pc;
    logic      halted;
    logic      halt_set;
    dmem_req_t dmem;
  } ex_t;

  // result stage, also the output register
  typedef struct packed {
    logic      wr;
    logic      ld;
    logic      rd_mem;
    reg_addr_t dst;
    byte_t     val;
    byte_t     rv;
    byte_t     next_pc;
    logic      halted;
  } s2_t;

endpackage

// ===== rtl/rie_regfile.sv =====
module rie_regfile (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  rie_pkg::reg_addr_t rd_addr_a_i,
  input  rie_pkg::reg_addr_t rd_addr_b_i,
  input  rie_pkg::reg_addr_t rd_addr_c_i,
  input  rie_pkg::wb_t      wb_i,
  output rie_pkg::byte_t    rd_data_a_o,
  output rie_pkg::byte_t    rd_data_b_o,
  output rie_pkg::byte_t    rd_data_c_o
);
  import rie_pkg::*;

  // two copies written together give three read ports
  byte_t bank_a [NUM_REGS];
  byte_t bank_b [NUM_REGS];

  logic [NUM_REGS-1:0] vld_q;
  byte_t rd_a_q, rd_b_q, rd_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wb_i.en) begin
      vld_q[wb_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_i.en) begin
      bank_a[wb_i.addr] <= wb_i.data;
      bank_b[wb_i.addr] <= wb_i.data;
    end
  end

  // write-through: a read at the edge of a write sees the new byte
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wb_i.en && wb_i.addr == rd_addr_a_i) begin
        rd_a_q <= wb_i.data;
      end else if (!vld_q[rd_addr_a_i]) begin
        rd_a_q <= '0;
      end else begin
        rd_a_q <= bank_a[rd_addr_a_i];
      end

      if (wb_i.en && wb_i.addr == rd_addr_b_i) begin
        rd_b_q <= wb_i.data;
      end else if (!vld_q[rd_addr_b_i]) begin
        rd_b_q <= '0;
      end else begin
        rd_b_q <= bank_a[rd_addr_b_i];
      end

      if (wb_i.en && wb_i.addr == rd_addr_c_i) begin
        rd_c_q <= wb_i.data;
      end else if (!vld_q[rd_addr_c_i]) begin
        rd_c_q <= '0;
      end else begin
        rd_c_q <= bank_b[rd_addr_c_i];
      end
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;
  assign rd_data_c_o = rd_c_q;

endmodule

// ===== rtl/rie_dmem.sv =====
module rie_dmem #(
  parameter int unsigned DATA_WORDS = rie_pkg::DATA_WORDS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rie_pkg::dmem_req_t req_i,
  output rie_pkg::byte_t    rd_data_o
);
  import rie_pkg::*;

  localparam int unsigned AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  // fold of the 8-bit address onto the memory depth
  logic [AW-1:0] mod_tbl [ADDR_SPACE];

  for (genvar g = 0; g < ADDR_SPACE; g++) begin : g_mod
    localparam int unsigned ModV = g % DATA_WORDS;
    assign mod_tbl[g] = AW'(ModV);
  end

  byte_t mem [DATA_WORDS];
  logic [DATA_WORDS-1:0] vld_q;
  logic [AW-1:0] idx;
  byte_t rd_q;
  logic  rd_vld_q;

  assign idx = mod_tbl[req_i.addr];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.en && req_i.we) begin
      vld_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[idx] <= req_i.wdata;
      end
      rd_q     <= mem[idx];
      rd_vld_q <= vld_q[idx];
    end
  end

  // never-written bytes read as zero
  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== rtl/rie_exec.sv =====
module rie_exec (
  input  rie_pkg::s1_t   s1_i,
  input  rie_pkg::byte_t op_a_i,
  input  rie_pkg::byte_t op_b_i,
  input  rie_pkg::byte_t op_c_i,
  input  logic           halt_i,
  output rie_pkg::ex_t   ex_o
);
  import rie_pkg::*;

  op_e         op;
  byte_t       p1;
  byte_t       ld_addr;
  logic [15:0] prod;

  assign op      = op_e'(s1_i.instr[15:12]);
  assign p1      = 8'(s1_i.pc + 8'd1);
  assign ld_addr = 8'(op_a_i + {4'b0000, s1_i.instr[3:0]});
  assign prod    = {8'h00, op_a_i} * {8'h00, op_b_i};

  always_comb begin
    ex_o          = '0;
    ex_o.dst      = s1_i.rc;
    ex_o.dmem.addr  = s1_i.access_addr;
    ex_o.dmem.wdata = s1_i.write_value;

    unique case (s1_i.func)
      FN_EXEC: begin
        if (halt_i) begin
          ex_o.next_pc = s1_i.pc;
        end else begin
          ex_o.next_pc = p1;
          unique case (op)
            OP_ADD: begin
              ex_o.wr  = 1'b1;
              ex_o.val = 8'(op_a_i + op_b_i);
            end
            OP_SUB: begin
              ex_o.wr  = 1'b1;
              ex_o.val = 8'(op_a_i - op_b_i);
            end
            OP_MUL: begin
              ex_o.wr  = 1'b1;
              ex_o.val = prod[7:0];
            end
            OP_INC: begin
              ex_o.wr  = 1'b1;
              ex_o.val = 8'(op_c_i + 8'd1);
            end
            OP_AND: begin
              ex_o.wr  = 1'b1;
              ex_o.val = op_a_i & op_b_i;
            end
            OP_OR: begin
              ex_o.wr  = 1'b1;
              ex_o.val = op_a_i | op_b_i;
            end
            OP_NOT: begin
              ex_o.wr  = 1'b1;
              ex_o.val = ~op_a_i;
            end
            OP_XOR: begin
              ex_o.wr  = 1'b1;
              ex_o.val = op_a_i ^ op_b_i;
            end
            OP_LOAD: begin
              ex_o.wr        = 1'b1;
              ex_o.ld        = 1'b1;
              ex_o.dmem.en   = 1'b1;
              ex_o.dmem.addr = ld_addr;
            end
            OP_STORE: begin
              ex_o.dmem.en    = 1'b1;
              ex_o.dmem.we    = 1'b1;
              ex_o.dmem.addr  = ld_addr;
              ex_o.dmem.wdata = op_c_i;
            end
            OP_JUMP: begin
              ex_o.next_pc = 8'(p1 + s1_i.instr[11:4]);
            end
            OP_BRZ: begin
              if (op_c_i == 8'h00) begin
                ex_o.next_pc = 8'(p1 + s1_i.instr[7:0]);
              end
            end
            OP_HALT: begin
              ex_o.halt_set = 1'b1;
              ex_o.next_pc  = s1_i.pc;
            end
            default: begin
            end
          endcase
        end
      end
      FN_WR_MEM: begin
        ex_o.dmem.en = 1'b1;
        ex_o.dmem.we = 1'b1;
      end
      FN_RD_MEM: begin
        ex_o.dmem.en = 1'b1;
        ex_o.rd_mem  = 1'b1;
      end
      FN_WR_REG: begin
        ex_o.wr  = 1'b1;
        ex_o.val = s1_i.write_value;
      end
      FN_RD_REG: begin
        ex_o.rv = op_c_i;
      end
      default: begin
      end
    endcase

    ex_o.halted = halt_i | ex_o.halt_set;
  end

endmodule

// ===== rtl/eight_bit_risc_instruction_executor_core.sv =====
// Channel    Dir  Handshake                     Payload
// s_axis     in   s_axis_tvalid/s_axis_tready   tuser: func; tdata: instruction and access word
// m_axis     out  m_axis_tvalid/m_axis_tready   tdata: next_pc, halted, read_value
//
// One word in per clock while the result port is not stalled; a taken word passes the
// issue register (with the register file read beside it), then the result register.
// The register file is read at the accept edge; the data memory is read and written
// in the issue stage, so loads and stores keep program order.
// Reset clears the valid bits of both stores and the halt flag; no clearing pass.
// A stalled result holds its register; the issue stage still takes one word behind it.
module eight_bit_risc_instruction_executor_core #(
  parameter int unsigned DATA_WORDS = rie_pkg::DATA_WORDS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // [2:0] func
  // [15:0] instr_word, [23:16] instr_pc, [31:24] access_addr,
  // [35:32] access_reg, [43:36] write_value, [47:44] zero
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] next_pc, [8] halted, [16:9] read_value, [23:17] zero
  output logic [23:0] m_axis_tdata
);
  import rie_pkg::*;

  logic      s_acc;
  logic      adv;
  func_e     in_func;
  reg_addr_t rd_c_addr;

  logic  v1_q, v1_d;
  s1_t   s1_q, s1_d;
  logic  v2_q, v2_d;
  s2_t   s2_q, s2_d;
  logic  halt_q, halt_d;

  byte_t     rd_a, rd_b, rd_c;
  byte_t     op_a, op_b, op_c;
  byte_t     wb_data;
  byte_t     dmem_rd;
  byte_t     read_value;
  wb_t       wb;
  dmem_req_t dreq;
  ex_t       ex;

  // ---------------------------------------------------------------------------
  // Handshake: issue stage moves on when the result register is free or drains
  // ---------------------------------------------------------------------------
  assign adv           = v1_q && (!v2_q || m_axis_tready);
  assign s_axis_tready = !v1_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Input decode and register file read at the accept edge
  // ---------------------------------------------------------------------------
  assign in_func   = func_e'(s_axis_tuser);
  assign rd_c_addr = (in_func == FN_EXEC) ? s_axis_tdata[11:8] : s_axis_tdata[35:32];

  always_comb begin
    s1_d.func        = in_func;
    s1_d.instr       = s_axis_tdata[15:0];
    s1_d.pc          = s_axis_tdata[23:16];
    s1_d.access_addr = s_axis_tdata[31:24];
    s1_d.write_value = s_axis_tdata[43:36];
    s1_d.rc          = rd_c_addr;
  end

  // writeback retires with the result word
  assign wb_data = s2_q.ld ? dmem_rd : s2_q.val;
  assign wb.en   = v2_q && m_axis_tready && s2_q.wr;
  assign wb.addr = s2_q.dst;
  assign wb.data = wb_data;

  rie_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (s_acc),
    .rd_addr_a_i (s_axis_tdata[7:4]),
    .rd_addr_b_i (s_axis_tdata[3:0]),
    .rd_addr_c_i (rd_c_addr),
    .wb_i        (wb),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b),
    .rd_data_c_o (rd_c)
  );

  // ---------------------------------------------------------------------------
  // Issue stage: the result register holds the only older write not yet in
  // the register file, so forward from it
  // ---------------------------------------------------------------------------
  assign op_a = (v2_q && s2_q.wr && s2_q.dst == s1_q.instr[7:4]) ? wb_data : rd_a;
  assign op_b = (v2_q && s2_q.wr && s2_q.dst == s1_q.instr[3:0]) ? wb_data : rd_b;
  assign op_c = (v2_q && s2_q.wr && s2_q.dst == s1_q.rc)         ? wb_data : rd_c;

  rie_exec u_exec (
    .s1_i   (s1_q),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .op_c_i (op_c),
    .halt_i (halt_q),
    .ex_o   (ex)
  );

  always_comb begin
    dreq    = ex.dmem;
    dreq.en = ex.dmem.en && adv;
  end

  rie_dmem #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (dreq),
    .rd_data_o (dmem_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage control
  // ---------------------------------------------------------------------------
  always_comb begin
    v1_d   = v1_q;
    v2_d   = v2_q;
    halt_d = halt_q;
    if (s_acc) begin
      v1_d = 1'b1;
    end else if (adv) begin
      v1_d = 1'b0;
    end
    if (adv) begin
      v2_d = 1'b1;
    end else if (m_axis_tready) begin
      v2_d = 1'b0;
    end
    if (adv && ex.halt_set) begin
      halt_d = 1'b1;
    end
  end

  always_comb begin
    s2_d.wr      = ex.wr;
    s2_d.ld      = ex.ld;
    s2_d.rd_mem  = ex.rd_mem;
    s2_d.dst     = ex.dst;
    s2_d.val     = ex.val;
    s2_d.rv      = ex.rv;
    s2_d.next_pc = ex.next_pc;
    s2_d.halted  = ex.halted;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      halt_q <= 1'b0;
    end else begin
      v1_q   <= v1_d;
      v2_q   <= v2_d;
      halt_q <= halt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_q <= s1_d;
    end
    if (adv) begin
      s2_q <= s2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result word
  // ---------------------------------------------------------------------------
  assign read_value    = s2_q.rd_mem ? dmem_rd : s2_q.rv;
  assign m_axis_tvalid = v2_q;
  assign m_axis_tdata  = {7'b0000000, read_value, s2_q.halted, s2_q.next_pc};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // halt is sticky
  a_halt_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

  // the result register is always the newest word past issue, so its flag is current
  a_halt_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (s2_q.halted == halt_q))
    else $error("halted bit out of step with halt flag");

  // both stages full and output stalled: no new word may be taken
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("word accepted into a full pipe");

  // memory is only touched when the issue stage moves on
  a_dmem_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.en |-> (v1_q && (!v2_q || m_axis_tready)))
    else $error("data memory access without issue advance");

endmodule
